// File: hdl/omrq_pkg.sv
// package for the overwriting message ring queue
// function codes, status codes, register indexes and fixed field widths
// used by omrq_cfg and the top level; depends on nothing
package omrq_pkg;

  localparam int FUNC_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 4;
  localparam int CAP_W      = 5;
  localparam int STATUS_W   = 3;
  localparam int MSGSZ_W    = 5;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef logic [FUNC_W-1:0]    func_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam func_t FN_WRITE = 3'd0;
  localparam func_t FN_READ  = 3'd1;
  localparam func_t FN_PEEK  = 3'd2;
  localparam func_t FN_CLEAR = 3'd3;
  localparam func_t FN_COUNT = 3'd4;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_OVERWROTE = 3'd1;
  localparam status_t ST_TOO_LONG  = 3'd2;
  localparam status_t ST_EMPTY     = 3'd3;
  localparam status_t ST_TOO_SMALL = 3'd4;
  localparam status_t ST_BAD_INDEX = 3'd5;

  localparam cfg_idx_t REG_QUEUE_SLOTS = 1'b0;
  localparam cfg_idx_t REG_MAX_BYTES   = 1'b1;

  localparam logic [CFG_DATA_W-1:0] QUEUE_SLOTS_RST = 5'd16;
  localparam logic [CFG_DATA_W-1:0] MAX_BYTES_RST   = 5'd16;

endpackage

// File: hdl/omrq_ram.sv
// simple dual-port synchronous ram, one write and one read port
// read data registered, updated only on a read enable; no dependencies
module omrq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/omrq_cfg.sv
// configuration registers of the ring queue with saturation to legal ranges
// depends on omrq_pkg; flags a ring clear when the slot count is written
module omrq_cfg
  import omrq_pkg::*;
#(
  parameter int SLOTS         = 16,
  parameter int MAX_MSG_BYTES = 16,
  parameter int ES_W          = $clog2(SLOTS + 1),
  parameter int SZ_W          = $clog2(MAX_MSG_BYTES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [ES_W-1:0]       eff_slots,
  output logic [SZ_W-1:0]       eff_max,
  output logic                  ring_clear
);

  logic [CFG_DATA_W-1:0] queue_slots_r;
  logic [CFG_DATA_W-1:0] max_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_slots_r <= QUEUE_SLOTS_RST;
      max_bytes_r   <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUEUE_SLOTS: queue_slots_r <= cfg_data;
        REG_MAX_BYTES:   max_bytes_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ring_clear = cfg_we && (cfg_index == REG_QUEUE_SLOTS);

  always_comb begin
    if (int'(queue_slots_r) > SLOTS) begin
      eff_slots = ES_W'(SLOTS);
    end else if (queue_slots_r < CFG_DATA_W'(2)) begin
      eff_slots = ES_W'(2);
    end else begin
      eff_slots = ES_W'(queue_slots_r);
    end
    if (int'(max_bytes_r) > MAX_MSG_BYTES) begin
      eff_max = SZ_W'(MAX_MSG_BYTES);
    end else if (max_bytes_r == '0) begin
      eff_max = SZ_W'(1);
    end else begin
      eff_max = SZ_W'(max_bytes_r);
    end
  end

endmodule

// File: hdl/overwriting_message_ring_queue.sv
// Ring of message slots kept in two synchronous rams: a payload ram of one row per slot and a
// size table of one entry per slot. Write, clear and count items are taken in the idle state, so
// a message streams in at one byte a cycle unless in_stall is high. A read of an empty ring and
// a peek with a bad index also answer from the idle state. A read or peek that answers with a
// single result after the size lookup (reader too small, empty message) goes through the size
// state; one that streams a message does the size table lookup, then sends one byte a cycle,
// unless the output stalls, through the payload ram's single read port. While a read or peek
// streams, no item is accepted; any item waits while the output register holds an unconsumed
// beat. No clearing pass after reset. Writing queue_slots empties the ring and drops a partly
// written message; depends on omrq_pkg, omrq_cfg and omrq_ram
module overwriting_message_ring_queue
  import omrq_pkg::*;
#(
  parameter int SLOTS         = 16,
  parameter int MAX_MSG_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  func_t                 in_func,
  input  logic [BYTE_W-1:0]     in_in_byte,
  input  logic                  in_has_byte,
  input  logic                  in_end_of_msg,
  input  logic [IDX_W-1:0]      in_peek_index,
  input  logic [CAP_W-1:0]      in_out_capacity,
  output logic                  out_valid,
  input  logic                  out_stall,
  output status_t               out_status,
  output logic [BYTE_W-1:0]     out_out_byte,
  output logic                  out_out_byte_valid,
  output logic [MSGSZ_W-1:0]    out_msg_size,
  output logic [COUNT_W-1:0]    out_queued_count,
  output logic                  out_last_of_run,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ES_W   = $clog2(SLOTS + 1);
  localparam int SZ_W   = $clog2(MAX_MSG_BYTES + 1);
  localparam int OFF_W  = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int PAY_AW = SLOT_W + OFF_W;
  localparam int PAY_DEPTH = SLOTS * (1 << OFF_W);
  localparam int CW     = (SZ_W > CAP_W) ? SZ_W : CAP_W;
  localparam int PW     = ((ES_W > IDX_W) ? ES_W : IDX_W) + 2;

  typedef enum logic [1:0] {S_IDLE, S_SIZE, S_STREAM} state_t;

  // configuration
  logic [ES_W-1:0] eff_slots;
  logic [SZ_W-1:0] eff_max;
  logic            ring_clear;

  omrq_cfg #(
    .SLOTS         (SLOTS),
    .MAX_MSG_BYTES (MAX_MSG_BYTES),
    .ES_W          (ES_W),
    .SZ_W          (SZ_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eff_slots  (eff_slots),
    .eff_max    (eff_max),
    .ring_clear (ring_clear)
  );

  // ring state
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0] queued_r, queued_nxt;
  logic [SZ_W-1:0]   stage_len_r, stage_len_nxt;
  logic              stage_ovf_r, stage_ovf_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [SZ_W-1:0]   size_r, size_nxt;
  logic [SZ_W-1:0]   cnt_r, cnt_nxt;

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_bv_r;
  logic [MSGSZ_W-1:0]  out_size_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_last_r;

  // beat being formed
  logic              emit;
  status_t           e_status;
  logic [BYTE_W-1:0] e_byte;
  logic              e_bv;
  logic [SZ_W-1:0]   e_size;
  logic              e_last;
  logic [CW-1:0]     e_size_ext;
  logic [PW-1:0]     q_ext;

  // ram ports
  logic              pay_we, pay_re;
  logic [PAY_AW-1:0] pay_waddr, pay_raddr;
  logic [BYTE_W-1:0] pay_rdata;
  logic [OFF_W-1:0]  rd_off;
  logic              size_we, size_re;
  logic [SLOT_W-1:0] size_raddr;
  logic [SZ_W-1:0]   size_rdata;

  // helpers
  logic              out_ok, in_acc;
  logic [SLOT_W-1:0] head_inc, tail_inc, peek_slot;
  logic [PW-1:0]     peek_sum;
  logic [SZ_W-1:0]   stg_len, cnt_inc;
  logic              stg_ovf;

  assign out_ok   = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_ok);
  assign in_acc   = in_valid && !in_stall;

  assign head_inc = ((ES_W'(head_r) + ES_W'(1)) == eff_slots) ? '0 : head_r + SLOT_W'(1);
  assign tail_inc = ((ES_W'(tail_r) + ES_W'(1)) == eff_slots) ? '0 : tail_r + SLOT_W'(1);
  // head + 1 + index stays below twice the slot count when the index is in range
  assign peek_sum  = PW'(head_r) + PW'(1) + PW'(in_peek_index);
  assign peek_slot = (peek_sum >= PW'(eff_slots)) ? SLOT_W'(peek_sum - PW'(eff_slots))
                                                  : SLOT_W'(peek_sum);
  assign cnt_inc = cnt_r + SZ_W'(1);
  assign rd_off  = (state_r == S_SIZE) ? '0 : cnt_inc[OFF_W-1:0];
  assign pay_raddr = {rd_slot_r, rd_off};
  assign pay_waddr = {tail_inc, stage_len_r[OFF_W-1:0]};

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    queued_nxt    = queued_r;
    stage_len_nxt = stage_len_r;
    stage_ovf_nxt = stage_ovf_r;
    rd_slot_nxt   = rd_slot_r;
    cap_nxt       = cap_r;
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    e_status      = ST_OK;
    e_byte        = '0;
    e_bv          = 1'b0;
    e_size        = '0;
    e_last        = 1'b1;
    pay_we        = 1'b0;
    pay_re        = 1'b0;
    size_we       = 1'b0;
    size_re       = 1'b0;
    size_raddr    = head_inc;
    stg_len       = stage_len_r;
    stg_ovf       = stage_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FN_WRITE: begin
              if (in_has_byte) begin
                if (stage_len_r < eff_max) begin
                  pay_we  = 1'b1;
                  stg_len = stage_len_r + SZ_W'(1);
                end else begin
                  stg_ovf = 1'b1;
                end
              end
              if (in_end_of_msg) begin
                emit = 1'b1;
                // a lowered limit can leave a staged length above it
                if (stg_ovf || (stg_len > eff_max)) begin
                  e_status = ST_TOO_LONG;
                end else begin
                  size_we  = 1'b1;
                  tail_nxt = tail_inc;
                  if ((ES_W'(queued_r) + ES_W'(1)) == eff_slots) begin
                    head_nxt = head_inc;
                    e_status = ST_OVERWROTE;
                  end else begin
                    queued_nxt = queued_r + SLOT_W'(1);
                  end
                end
                stage_len_nxt = '0;
                stage_ovf_nxt = 1'b0;
              end else begin
                stage_len_nxt = stg_len;
                stage_ovf_nxt = stg_ovf;
              end
            end
            FN_READ: begin
              if (queued_r == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                head_nxt    = head_inc;
                queued_nxt  = queued_r - SLOT_W'(1);
                size_re     = 1'b1;
                size_raddr  = head_inc;
                rd_slot_nxt = head_inc;
                cap_nxt     = in_out_capacity;
                state_nxt   = S_SIZE;
              end
            end
            FN_PEEK: begin
              if (PW'(in_peek_index) >= PW'(queued_r)) begin
                emit     = 1'b1;
                e_status = ST_BAD_INDEX;
              end else begin
                size_re     = 1'b1;
                size_raddr  = peek_slot;
                rd_slot_nxt = peek_slot;
                cap_nxt     = in_out_capacity;
                state_nxt   = S_SIZE;
              end
            end
            FN_CLEAR: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              queued_nxt    = '0;
              stage_len_nxt = '0;
              stage_ovf_nxt = 1'b0;
              emit          = 1'b1;
            end
            default: begin
              // count query and unused codes
              emit = 1'b1;
            end
          endcase
        end
      end
      S_SIZE: begin
        // fetch the first byte while the size is examined
        pay_re = 1'b1;
        if (CW'(size_rdata) > CW'(cap_r)) begin
          if (out_ok) begin
            emit      = 1'b1;
            e_status  = ST_TOO_SMALL;
            e_size    = size_rdata;
            state_nxt = S_IDLE;
          end
        end else if (size_rdata == '0) begin
          if (out_ok) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          size_nxt  = size_rdata;
          cnt_nxt   = '0;
          state_nxt = S_STREAM;
        end
      end
      S_STREAM: begin
        if (out_ok) begin
          emit   = 1'b1;
          e_byte = pay_rdata;
          e_bv   = 1'b1;
          e_size = size_r;
          e_last = (cnt_inc == size_r);
          if (cnt_inc == size_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_inc;
            pay_re  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ring_clear) begin
      head_nxt      = '0;
      tail_nxt      = '0;
      queued_nxt    = '0;
      stage_len_nxt = '0;
      stage_ovf_nxt = 1'b0;
    end
  end

  assign e_size_ext = CW'(e_size);
  assign q_ext      = PW'(queued_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      queued_r    <= '0;
      stage_len_r <= '0;
      stage_ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      queued_r    <= queued_nxt;
      stage_len_r <= stage_len_nxt;
      stage_ovf_r <= stage_ovf_nxt;
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
    rd_slot_r <= rd_slot_nxt;
    cap_r     <= cap_nxt;
    size_r    <= size_nxt;
    cnt_r     <= cnt_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_byte_r   <= e_byte;
      out_bv_r     <= e_bv;
      out_size_r   <= e_size_ext[MSGSZ_W-1:0];
      out_count_r  <= q_ext[COUNT_W-1:0];
      out_last_r   <= e_last;
    end
  end

  omrq_ram #(
    .DEPTH (PAY_DEPTH),
    .WIDTH (BYTE_W),
    .AW    (PAY_AW)
  ) u_payload (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (in_in_byte),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  omrq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SZ_W),
    .AW    (SLOT_W)
  ) u_sizes (
    .clk   (clk),
    .we    (size_we),
    .waddr (tail_inc),
    .wdata (stg_len),
    .re    (size_re),
    .raddr (size_raddr),
    .rdata (size_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_out_byte       = out_byte_r;
  assign out_out_byte_valid = out_bv_r;
  assign out_msg_size       = out_size_r;
  assign out_queued_count   = out_count_r;
  assign out_last_of_run    = out_last_r;

  // the ring never holds as many messages as it has slots
  a_queued_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ES_W'(queued_r) < eff_slots)
    else $error("queued count reached the slot count");

  // the stream counter stays inside the message being sent
  a_stream_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STREAM) |-> (cnt_r < size_r) && (size_r != '0))
    else $error("stream counter outside message");

  // a pop of a non-empty ring goes to the size lookup
  a_read_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == FN_READ) && (queued_r != '0) && !ring_clear)
      |=> (state_r == S_SIZE) && (queued_r == $past(queued_r) - SLOT_W'(1)))
    else $error("read did not pop into size lookup");

  // a data beat always carries ok status
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bv_r) |-> (out_status_r == ST_OK))
    else $error("data beat with error status");

endmodule
